// ----- hw/rtl/lagged_xor_random_generator_top_macros.svh -----
// assertion macros used by the checker file
// each macro expects signals named clk and rst in the scope where it is used
`ifndef LAGGED_XOR_RANDOM_GENERATOR_TOP_MACROS_SVH
`define LAGGED_XOR_RANDOM_GENERATOR_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define LXRG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lxrg assertion failed");

// next-cycle implication, checked outside reset
`define LXRG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lxrg assertion failed");

`endif

// ----- hw/rtl/lxrg_pkg.sv -----
// ----------------------------------------------------------------------------
// lxrg_pkg
// Shared types and constants of the lagged-XOR random generator.
// ----------------------------------------------------------------------------
package lxrg_pkg;

  // generator geometry
  localparam int TABLE_LEN = 98;
  localparam int LAG       = 27;
  localparam int LAG_MOD   = LAG % TABLE_LEN;
  localparam int PTR_W     = $clog2(TABLE_LEN);

  // field widths
  localparam int WORD_W  = 32;
  localparam int IDX_W   = 7;
  localparam int BOUND_W = 31;

  // input tdata layout, lowest bit first
  localparam int IDX_LSB   = 0;
  localparam int WORD_LSB  = IDX_LSB + IDX_W;
  localparam int LO_LSB    = WORD_LSB + WORD_W;
  localparam int HI_LSB    = LO_LSB + BOUND_W;
  localparam int IN_BITS   = HI_LSB + BOUND_W;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int IN_USER_W = 2;

  // output layout
  localparam int OUT_DATA_W = WORD_W;
  localparam int OUT_USER_W = 1;

  // request kinds
  typedef enum logic [IN_USER_W-1:0] {
    MODE_SEED    = 2'd0,
    MODE_POINTER = 2'd1,
    MODE_RAW     = 2'd2,
    MODE_RANGE   = 2'd3
  } mode_t;

  // result status codes
  typedef enum logic [OUT_USER_W-1:0] {
    STATUS_OK       = 1'b0,
    STATUS_BAD_SPAN = 1'b1
  } status_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_EMIT
  } state_t;

  // divider handshake
  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [WORD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] remainder;
  } div_rsp_t;

endpackage

// ----- hw/rtl/lxrg_ram.sv -----
// ----------------------------------------------------------------------------
// lxrg_ram
// Generic RAM, one write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module lxrg_ram #(
  parameter int DEPTH = 98,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read ports, registered read data
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ----- hw/rtl/lxrg_divider.sv -----
// ----------------------------------------------------------------------------
// lxrg_divider
// Serial restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module lxrg_divider (
  input  logic                clk,
  input  logic                rst,
  input  lxrg_pkg::div_req_t  req,
  output lxrg_pkg::div_rsp_t  rsp
);

  localparam int W     = lxrg_pkg::WORD_W;
  localparam int CNT_W = $clog2(W + 1);

  logic             busy;
  logic [CNT_W-1:0] count;
  logic [W-1:0]     rem;
  logic [W-1:0]     dvd;
  logic [W-1:0]     dvs;
  logic             done;
  logic [W:0]       trial;
  logic             fits;

  // shift in the next dividend bit and try the subtraction
  always_comb begin
    trial = {rem, dvd[W-1]};
    fits  = trial >= {1'b0, dvs};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= CNT_W'(W);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      dvd <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      dvd <= {dvd[W-2:0], 1'b0};
      if (fits) begin
        rem <= W'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[W-1:0];
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.remainder = rem;

endmodule

// ----- hw/rtl/lagged_xor_random_generator_top.sv -----
// Seeding, setting the pointer or an inverted range go straight to the emit state;
// a raw draw first reads the table, and a range draw then runs the remainder unit.
// One request at a time; the next is taken once the result is loaded, and a range
// draw also waits on the 32-step serial remainder unit.
// Reset (rst, synchronous) zeroes the pointer and empties the output register;
// table words are undefined until seeded and are not cleared.
// ----------------------------------------------------------------------------
// lagged_xor_random_generator_top
// GFSR generator over a word table in RAM with a lagged XOR feedback.
// ----------------------------------------------------------------------------
module lagged_xor_random_generator_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // seed_index, seed_word, range_low, range_high, zero pad
  input  logic [lxrg_pkg::IN_DATA_W-1:0]     s_tdata,
  // mode
  input  logic [lxrg_pkg::IN_USER_W-1:0]     s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // value
  output logic [lxrg_pkg::OUT_DATA_W-1:0]    m_tdata,
  // status
  output logic [lxrg_pkg::OUT_USER_W-1:0]    m_tuser
);

  localparam int PW = lxrg_pkg::PTR_W;
  localparam int W  = lxrg_pkg::WORD_W;
  localparam int BW = lxrg_pkg::BOUND_W;

  lxrg_pkg::state_t  state, state_next;
  lxrg_pkg::mode_t   in_mode;
  logic [lxrg_pkg::IDX_W-1:0] in_idx;
  logic [W-1:0]      in_word;
  logic [BW-1:0]     in_lo;
  logic [BW-1:0]     in_hi;
  logic              accept;
  logic              idx_ok;
  logic              span_bad;

  logic [PW-1:0]     pointer;
  logic [PW-1:0]     ptr_adv;
  logic [PW:0]       ahead_sum;
  logic [PW-1:0]     ahead;
  logic [PW-1:0]     draw_ptr;
  logic              is_range;
  logic [BW-1:0]     lo;
  logic [W-1:0]      span;
  logic [W-1:0]      res_value;
  logic              res_status;
  logic              out_free;

  logic              ram_we;
  logic [PW-1:0]     ram_waddr;
  logic [W-1:0]      ram_wdata;
  logic [W-1:0]      rd_cur;
  logic [W-1:0]      rd_ahead;
  logic [W-1:0]      mixed;

  lxrg_pkg::div_req_t div_req;
  lxrg_pkg::div_rsp_t div_rsp;

  // request fields
  assign in_mode  = lxrg_pkg::mode_t'(s_tuser);
  assign in_idx   = s_tdata[lxrg_pkg::IDX_LSB +: lxrg_pkg::IDX_W];
  assign in_word  = s_tdata[lxrg_pkg::WORD_LSB +: W];
  assign in_lo    = s_tdata[lxrg_pkg::LO_LSB +: BW];
  assign in_hi    = s_tdata[lxrg_pkg::HI_LSB +: BW];
  assign s_tready = (state == lxrg_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign idx_ok   = 32'(in_idx) < 32'(lxrg_pkg::TABLE_LEN);
  assign span_bad = in_hi < in_lo;
  assign out_free = !m_tvalid || m_tready;

  // advanced pointer and lagged partner, both wrapped
  always_comb begin
    if (pointer == PW'(lxrg_pkg::TABLE_LEN - 1)) begin
      ptr_adv = '0;
    end else begin
      ptr_adv = pointer + 1'b1;
    end
    ahead_sum = {1'b0, ptr_adv} + (PW + 1)'(lxrg_pkg::LAG_MOD);
    if (32'(ahead_sum) >= 32'(lxrg_pkg::TABLE_LEN)) begin
      ahead = PW'(ahead_sum - (PW + 1)'(lxrg_pkg::TABLE_LEN));
    end else begin
      ahead = ahead_sum[PW-1:0];
    end
  end

  assign mixed = rd_cur ^ rd_ahead;

  // table write port: seeding in idle, feedback write-back in read
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = PW'(in_idx);
    ram_wdata = in_word;
    if (state == lxrg_pkg::ST_READ) begin
      ram_we    = 1'b1;
      ram_waddr = draw_ptr;
      ram_wdata = mixed;
    end else if (accept && in_mode == lxrg_pkg::MODE_SEED && idx_ok) begin
      ram_we = 1'b1;
    end
  end

  lxrg_ram #(
    .DEPTH (lxrg_pkg::TABLE_LEN),
    .WIDTH (W)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ptr_adv),
    .rdata_a (rd_cur),
    .raddr_b (ahead),
    .rdata_b (rd_ahead)
  );

  // remainder unit start
  always_comb begin
    div_req.start    = (state == lxrg_pkg::ST_READ) && is_range;
    div_req.dividend = mixed;
    div_req.divisor  = span;
  end

  lxrg_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      lxrg_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_mode == lxrg_pkg::MODE_RAW ||
              (in_mode == lxrg_pkg::MODE_RANGE && !span_bad)) begin
            state_next = lxrg_pkg::ST_READ;
          end else begin
            state_next = lxrg_pkg::ST_EMIT;
          end
        end
      end
      lxrg_pkg::ST_READ: begin
        state_next = is_range ? lxrg_pkg::ST_DIV : lxrg_pkg::ST_EMIT;
      end
      lxrg_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          state_next = lxrg_pkg::ST_EMIT;
        end
      end
      lxrg_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = lxrg_pkg::ST_IDLE;
        end
      end
      default: state_next = lxrg_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= lxrg_pkg::ST_IDLE;
      pointer  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && in_mode == lxrg_pkg::MODE_POINTER && idx_ok) begin
        pointer <= PW'(in_idx);
      end else if (state == lxrg_pkg::ST_READ) begin
        pointer <= draw_ptr;
      end
      if (state == lxrg_pkg::ST_EMIT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // request context and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      draw_ptr   <= ptr_adv;
      is_range   <= in_mode == lxrg_pkg::MODE_RANGE;
      lo         <= in_lo;
      span       <= W'(in_hi) - W'(in_lo) + W'(1);
      res_value  <= '0;
      res_status <= (in_mode == lxrg_pkg::MODE_RANGE && span_bad) ?
                    lxrg_pkg::STATUS_BAD_SPAN : lxrg_pkg::STATUS_OK;
    end
    if (state == lxrg_pkg::ST_READ && !is_range) begin
      res_value <= mixed;
    end
    if (state == lxrg_pkg::ST_DIV && div_rsp.done) begin
      res_value <= div_rsp.remainder + W'(lo);
    end
    if (state == lxrg_pkg::ST_EMIT && out_free) begin
      m_tdata <= res_value;
      m_tuser <= lxrg_pkg::OUT_USER_W'(res_status);
    end
  end

endmodule

// ----- hw/rtl/lxrg_checker.sv -----
// ----------------------------------------------------------------------------
// lxrg_checker
// Port-level checks of the generator, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "lagged_xor_random_generator_top_macros.svh"

module lxrg_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tvalid,
  input logic                               s_tready,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [lxrg_pkg::OUT_DATA_W-1:0]    m_tdata,
  input logic [lxrg_pkg::OUT_USER_W-1:0]    m_tuser
);

  // a stalled result holds its payload
  `LXRG_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // an inverted range always reports a zero value
  `LXRG_ASSERT_NOW(a_bad_span_zero, m_tvalid && m_tuser == lxrg_pkg::STATUS_BAD_SPAN,
    m_tdata == '0)

  // no result is presented right after reset
  `LXRG_ASSERT_NOW(a_reset_empty, $past(rst), !m_tvalid)

  // one request in flight: a taken request closes the input in the next cycle
  `LXRG_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)

endmodule

bind lagged_xor_random_generator_top lxrg_checker u_lxrg_checker (.*);

// ----- bench/tb_lagged_xor_random_generator_top.sv -----
// ----------------------------------------------------------------------------
// tb_lagged_xor_random_generator_top
// Self-checking bench for the lagged-XOR generator. Every table word is
// seeded first, then directed and random requests run through the stream
// ports. A scoreboard mirrors the table and pointer, predicts each result and
// checks the results in order. Random gaps and stalls fall on both sides.
// ----------------------------------------------------------------------------
module tb_lagged_xor_random_generator_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [lxrg_pkg::IDX_W-1:0]   idx_t;
  typedef logic [lxrg_pkg::WORD_W-1:0]  word_t;
  typedef logic [lxrg_pkg::BOUND_W-1:0] bound_t;

  localparam bound_t BOUND_MAX = '1;
  localparam word_t  WORD_MAX  = '1;
  localparam int     IDX_MAX   = (1 << lxrg_pkg::IDX_W) - 1;
  localparam int     N_RANDOM  = 1030;
  localparam int     PHASE_LEN = 230;

  // one awaited result
  typedef struct {
    word_t              value;
    lxrg_pkg::status_t  status;
  } result_t;

  // mirror of the generator state and the results still awaited
  class lxrg_scoreboard;
    word_t       words [lxrg_pkg::TABLE_LEN];
    int unsigned ptr;
    result_t     awaited [$];
    int unsigned errors, checked, seeds, moves, raws, ranges, bad_spans;

    // step the pointer with wrap and fold in the word LAG places ahead
    function word_t advance();
      int unsigned ahead;
      ptr = (ptr == lxrg_pkg::TABLE_LEN - 1) ? 0 : ptr + 1;
      ahead = (ptr + lxrg_pkg::LAG) % lxrg_pkg::TABLE_LEN;
      words[ptr] = words[ptr] ^ words[ahead];
      return words[ptr];
    endfunction

    function void note_request(lxrg_pkg::mode_t mode, idx_t idx, word_t word,
                               bound_t lo, bound_t hi);
      result_t r;
      word_t   span;
      r.value  = '0;
      r.status = lxrg_pkg::STATUS_OK;
      case (mode)
        lxrg_pkg::MODE_SEED: begin
          seeds++;
          if (idx < lxrg_pkg::TABLE_LEN) words[idx] = word;
        end
        lxrg_pkg::MODE_POINTER: begin
          moves++;
          if (idx < lxrg_pkg::TABLE_LEN) ptr = 32'(idx);
        end
        lxrg_pkg::MODE_RAW: begin
          raws++;
          r.value = advance();
        end
        lxrg_pkg::MODE_RANGE: begin
          // inverted bounds leave table and pointer alone
          if (hi < lo) begin
            bad_spans++;
            r.status = lxrg_pkg::STATUS_BAD_SPAN;
          end else begin
            ranges++;
            span    = {1'b0, hi} - {1'b0, lo} + 32'd1;
            r.value = advance() % span + {1'b0, lo};
          end
        end
        default: ;
      endcase
      awaited.push_back(r);
    endfunction

    function void check_result(word_t value, logic [lxrg_pkg::OUT_USER_W-1:0] status);
      result_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, got value %h status %0d",
                 $time, value, status);
        return;
      end
      want = awaited.pop_front();
      checked++;
      if (value !== want.value) begin
        errors++;
        $display("%0t: value mismatch: expected %h, got %h", $time, want.value, value);
      end
      if (status !== want.status) begin
        errors++;
        $display("%0t: status mismatch: expected %0d, got %0d", $time, want.status, status);
      end
    endfunction
  endclass

  logic                              clk      = 1'b0;
  logic                              rst      = 1'b1;
  logic                              s_tvalid = 1'b0;
  logic                              s_tready;
  logic [lxrg_pkg::IN_DATA_W-1:0]    s_tdata  = '0;
  logic [lxrg_pkg::IN_USER_W-1:0]    s_tuser  = '0;
  logic                              m_tvalid;
  logic                              m_tready = 1'b0;
  logic [lxrg_pkg::OUT_DATA_W-1:0]   m_tdata;
  logic [lxrg_pkg::OUT_USER_W-1:0]   m_tuser;

  lxrg_scoreboard board = new;
  bit             no_idle;
  bit             valid_up;

  always #2 clk = ~clk;

  lagged_xor_random_generator_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // gap length: mostly short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // random bound and slot values cut to field width
  function automatic bound_t rand_bound();
    return bound_t'($urandom());
  endfunction

  function automatic idx_t rand_idx();
    return idx_t'($urandom());
  endfunction

  task automatic lower_valid();
    if (valid_up) begin
      s_tvalid <= 1'b0;
      valid_up = 1'b0;
    end
  endtask

  // present one request and hold it until the block takes it
  task automatic send_request(lxrg_pkg::mode_t mode, idx_t idx, word_t word,
                              bound_t lo, bound_t hi);
    logic [lxrg_pkg::IN_DATA_W-1:0] d;
    d = '0;
    d[lxrg_pkg::IDX_LSB +: lxrg_pkg::IDX_W]    = idx;
    d[lxrg_pkg::WORD_LSB +: lxrg_pkg::WORD_W]  = word;
    d[lxrg_pkg::LO_LSB +: lxrg_pkg::BOUND_W]   = lo;
    d[lxrg_pkg::HI_LSB +: lxrg_pkg::BOUND_W]   = hi;
    s_tdata  <= d;
    s_tuser  <= mode;
    s_tvalid <= 1'b1;
    valid_up = 1'b1;
    do @(posedge clk); while (!s_tready);
    board.note_request(mode, idx, word, lo, hi);
  endtask

  // random sender gap after a request
  task automatic rest();
    int unsigned n;
    if (no_idle || $urandom_range(0, 99) >= 35) return;
    n = pick_gap();
    lower_valid();
    repeat (n) @(posedge clk);
  endtask

  // stop sending until every awaited result is back
  task automatic drain();
    lower_valid();
    @(posedge clk);
    while (board.awaited.size() != 0) @(posedge clk);
  endtask

  // result side: check accepted results and stall at random
  initial begin
    int unsigned stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) board.check_result(m_tdata, m_tuser);
      if (stall > 0 && !no_idle) begin
        stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        stall = 0;
        if (!no_idle && $urandom_range(0, 99) < 20) stall = pick_gap();
      end
    end
  end

  // request side
  initial begin
    lxrg_pkg::mode_t mode;
    idx_t            idx;
    word_t           word;
    bound_t          lo, hi;
    int unsigned     pick;
    longint unsigned top;

    no_idle  = 1'b0;
    valid_up = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // seed the whole table so no draw reads an unwritten word
    for (int i = 0; i < lxrg_pkg::TABLE_LEN; i++) begin
      word = (i == 0) ? '0 : (i == 1) ? WORD_MAX : $urandom();
      send_request(lxrg_pkg::MODE_SEED, idx_t'(i), word, rand_bound(), rand_bound());
      rest();
    end

    // out-of-range seed slot and pointer are ignored
    send_request(lxrg_pkg::MODE_SEED, idx_t'(lxrg_pkg::TABLE_LEN), WORD_MAX,
                 rand_bound(), rand_bound());
    rest();
    send_request(lxrg_pkg::MODE_SEED, idx_t'(IDX_MAX), $urandom(), rand_bound(), rand_bound());
    rest();
    send_request(lxrg_pkg::MODE_POINTER, idx_t'(IDX_MAX), $urandom(),
                 rand_bound(), rand_bound());
    rest();
    send_request(lxrg_pkg::MODE_POINTER, idx_t'(lxrg_pkg::TABLE_LEN), $urandom(),
                 rand_bound(), rand_bound());
    rest();
    send_request(lxrg_pkg::MODE_RAW, rand_idx(), $urandom(), rand_bound(), rand_bound());
    rest();
    // pointer wraps to zero
    send_request(lxrg_pkg::MODE_POINTER, idx_t'(lxrg_pkg::TABLE_LEN - 1), $urandom(),
                 rand_bound(), rand_bound());
    rest();
    send_request(lxrg_pkg::MODE_RAW, rand_idx(), $urandom(), rand_bound(), rand_bound());
    rest();
    // lagged word wraps to slot zero
    send_request(lxrg_pkg::MODE_POINTER, idx_t'(lxrg_pkg::TABLE_LEN - lxrg_pkg::LAG - 1),
                 $urandom(), rand_bound(), rand_bound());
    rest();
    send_request(lxrg_pkg::MODE_RAW, rand_idx(), $urandom(), rand_bound(), rand_bound());
    rest();
    // range extremes, unit span and inverted bounds
    send_request(lxrg_pkg::MODE_RANGE, rand_idx(), $urandom(), '0, BOUND_MAX);
    rest();
    send_request(lxrg_pkg::MODE_RANGE, rand_idx(), $urandom(), BOUND_MAX, BOUND_MAX);
    rest();
    send_request(lxrg_pkg::MODE_RANGE, rand_idx(), $urandom(), '0, '0);
    rest();
    send_request(lxrg_pkg::MODE_RANGE, rand_idx(), $urandom(), 31'd5, 31'd4);
    rest();
    send_request(lxrg_pkg::MODE_RANGE, rand_idx(), $urandom(), BOUND_MAX, '0);
    rest();
    send_request(lxrg_pkg::MODE_RANGE, rand_idx(), $urandom(), 31'd1, BOUND_MAX);
    rest();
    send_request(lxrg_pkg::MODE_RANGE, rand_idx(), $urandom(), 31'h4000_0000, BOUND_MAX);
    rest();
    send_request(lxrg_pkg::MODE_SEED, idx_t'(lxrg_pkg::TABLE_LEN - 1), '0,
                 rand_bound(), rand_bound());
    rest();
    send_request(lxrg_pkg::MODE_POINTER, idx_t'(lxrg_pkg::TABLE_LEN - 2), $urandom(),
                 rand_bound(), rand_bound());
    rest();
    send_request(lxrg_pkg::MODE_RAW, rand_idx(), $urandom(), rand_bound(), rand_bound());
    rest();
    send_request(lxrg_pkg::MODE_RAW, rand_idx(), $urandom(), rand_bound(), rand_bound());
    rest();
    send_request(lxrg_pkg::MODE_RANGE, rand_idx(), $urandom(), 31'd1000, 31'd1999);
    drain();

    // random requests in phases: one phase without idling, one after a full drain
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % PHASE_LEN == 0) begin
        no_idle = (n / PHASE_LEN == 2);
        if (n / PHASE_LEN == 3) drain();
      end
      idx  = rand_idx();
      word = $urandom();
      lo   = rand_bound();
      hi   = rand_bound();
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        mode = lxrg_pkg::MODE_SEED;
      end else if (pick < 20) begin
        mode = lxrg_pkg::MODE_POINTER;
      end else if (pick < 48) begin
        mode = lxrg_pkg::MODE_RAW;
      end else begin
        mode = lxrg_pkg::MODE_RANGE;
      end
      if (mode == lxrg_pkg::MODE_SEED || mode == lxrg_pkg::MODE_POINTER) begin
        if ($urandom_range(0, 99) < 85) idx = idx_t'($urandom_range(0, lxrg_pkg::TABLE_LEN - 1));
        else idx = idx_t'($urandom_range(lxrg_pkg::TABLE_LEN, IDX_MAX));
      end
      // shape the bounds of a range draw
      if (mode == lxrg_pkg::MODE_RANGE) begin
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          lo = bound_t'($urandom_range(1, BOUND_MAX));
          hi = bound_t'($urandom_range(0, lo - 1));
        end else if (pick < 35) begin
          top = lo + $urandom_range(0, 20);
          hi  = (top > BOUND_MAX) ? BOUND_MAX : bound_t'(top);
        end else if (pick < 40) begin
          hi = BOUND_MAX;
          if ($urandom_range(0, 1)) lo = '0;
        end else if (pick < 45) begin
          hi = lo;
        end else if (hi < lo) begin
          {lo, hi} = {hi, lo};
        end
      end
      send_request(mode, idx, word, lo, hi);
      rest();
    end

    no_idle = 1'b0;
    drain();
    repeat (40) @(posedge clk);

    $display("covered %0d seeds, %0d pointer moves, %0d raw draws, %0d ranged draws",
             board.seeds, board.moves, board.raws, board.ranges);
    $display("%0d inverted ranges, %0d results checked, %0d mismatches",
             board.bad_spans, board.checked, board.errors);
    if (board.errors == 0 && board.awaited.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
